### rtl/m64h_pkg.sv
`default_nettype none

package m64h_pkg;

   // Hash constants
   localparam logic [63:0] HASH_MUL   = 64'hc6a4a7935bd1e995;
   localparam logic [31:0] MUL_LO     = HASH_MUL[31:0];
   localparam logic [31:0] MUL_HI     = HASH_MUL[63:32];
   localparam int          MIX_SHIFT  = 47;

   localparam int LENGTH_WIDTH_DEF = 32;
   localparam int CSR_INDEX_WIDTH  = 4;
   localparam int PC_WIDTH         = 4;
   localparam int WORD_BYTES       = 8;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SEED = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FOLD = 4'd1;

   // Multiplier operand sources
   localparam logic [2:0] SRC_LEN      = 3'd0;
   localparam logic [2:0] SRC_WORD     = 3'd1;
   localparam logic [2:0] SRC_TMP      = 3'd2;
   localparam logic [2:0] SRC_HASH     = 3'd3;
   localparam logic [2:0] SRC_HASH_MIX = 3'd4;

   // Write-back destinations
   localparam logic [2:0] DST_NONE    = 3'd0;
   localparam logic [2:0] DST_H_SEED  = 3'd1;
   localparam logic [2:0] DST_TMP_MIX = 3'd2;
   localparam logic [2:0] DST_H_XOR   = 3'd3;
   localparam logic [2:0] DST_H_PART  = 3'd4;
   localparam logic [2:0] DST_H_LOAD  = 3'd5;
   localparam logic [2:0] DST_OUT     = 3'd6;

   // Jump conditions
   localparam logic [2:0] COND_NEVER       = 3'd0;
   localparam logic [2:0] COND_ALWAYS      = 3'd1;
   localparam logic [2:0] COND_NOT_FIRST   = 3'd2;
   localparam logic [2:0] COND_NOT_FULL    = 3'd3;
   localparam logic [2:0] COND_NOT_PARTIAL = 3'd4;
   localparam logic [2:0] COND_NOT_LAST    = 3'd5;

   typedef struct packed {
      logic [2:0]          src;
      logic                issue;
      logic [2:0]          dest;
      logic [2:0]          cond;
      logic [PC_WIDTH-1:0] target;
      logic                fin;
   } ctl_type;

   typedef struct packed {
      logic first;
      logic full;
      logic partial;
      logic last;
   } flags_type;

   function automatic logic [63:0] shiftmix(input logic [63:0] v);
      shiftmix = v ^ (v >> MIX_SHIFT);
   endfunction

   function automatic ctl_type make_ctl(input logic [2:0] src, input logic issue,
                                        input logic [2:0] dest, input logic [2:0] cond,
                                        input logic [PC_WIDTH-1:0] target, input logic fin);
      ctl_type c;
      c.src    = src;
      c.issue  = issue;
      c.dest   = dest;
      c.cond   = cond;
      c.target = target;
      c.fin    = fin;
      make_ctl = c;
   endfunction

   // Microprogram: one control word per step
   function automatic ctl_type rom(input logic [PC_WIDTH-1:0] pc);
      ctl_type c;
      unique case (pc)
         // start of message: multiply length
         4'd0:    c = make_ctl(SRC_LEN, 1'b1, DST_NONE, COND_NOT_FIRST, 4'd2, 1'b0);
         4'd1:    c = make_ctl(SRC_LEN, 1'b0, DST_H_SEED, COND_NEVER, 4'd0, 1'b0);
         // full word: k*M, mix, *M, xor into hash
         4'd2:    c = make_ctl(SRC_WORD, 1'b1, DST_NONE, COND_NOT_FULL, 4'd6, 1'b0);
         4'd3:    c = make_ctl(SRC_WORD, 1'b0, DST_TMP_MIX, COND_NEVER, 4'd0, 1'b0);
         4'd4:    c = make_ctl(SRC_TMP, 1'b1, DST_NONE, COND_NEVER, 4'd0, 1'b0);
         4'd5:    c = make_ctl(SRC_TMP, 1'b0, DST_H_XOR, COND_ALWAYS, 4'd8, 1'b0);
         // partial word: xor masked bytes
         4'd6:    c = make_ctl(SRC_HASH, 1'b0, DST_NONE, COND_NOT_PARTIAL, 4'd10, 1'b0);
         4'd7:    c = make_ctl(SRC_HASH, 1'b0, DST_H_PART, COND_NEVER, 4'd0, 1'b0);
         // hash *= M
         4'd8:    c = make_ctl(SRC_HASH, 1'b1, DST_NONE, COND_NEVER, 4'd0, 1'b0);
         4'd9:    c = make_ctl(SRC_HASH, 1'b0, DST_H_LOAD, COND_NEVER, 4'd0, 1'b0);
         // finalize on last item
         4'd10:   c = make_ctl(SRC_HASH_MIX, 1'b1, DST_NONE, COND_NOT_LAST, 4'd12, 1'b0);
         4'd11:   c = make_ctl(SRC_HASH_MIX, 1'b0, DST_OUT, COND_NEVER, 4'd0, 1'b1);
         default: c = make_ctl(SRC_HASH, 1'b0, DST_NONE, COND_NEVER, 4'd0, 1'b1);
      endcase
      rom = c;
   endfunction

endpackage

`default_nettype wire

### rtl/m64h_mul.sv
`default_nettype none

module m64h_mul (
   input  wire logic        clock,
   input  wire logic        issue,
   input  wire logic [63:0] operand,
   output logic      [63:0] product
);
   import m64h_pkg::*;

   logic [63:0] p0_ff, p0_in;
   logic [31:0] p1_ff, p1_in;
   logic [31:0] p2_ff, p2_in;

   // Form the three partial products that reach the low 64 bits
   always_comb begin
      p0_in = 64'(operand[31:0]) * 64'(MUL_LO);
      p1_in = 32'(operand[31:0] * MUL_HI);
      p2_in = 32'(operand[63:32] * MUL_LO);
   end

   // Hold partial products until the next issue
   always_ff @(posedge clock) begin
      if (issue) begin
         p0_ff <= p0_in;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
      end
   end

   // Sum cross terms into the upper half
   assign product = {p0_ff[63:32] + p1_ff + p2_ff, p0_ff[31:0]};

endmodule

`default_nettype wire

### rtl/m64h_seq.sv
`default_nettype none

module m64h_seq (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                stall,
   input  wire m64h_pkg::flags_type flags,
   output logic                     busy,
   output m64h_pkg::ctl_type        ctl
);
   import m64h_pkg::*;

   logic [PC_WIDTH-1:0] pc_ff, pc_in;
   logic                busy_ff, busy_in;
   logic                take;

   assign ctl  = rom(pc_ff);
   assign busy = busy_ff;

   // Evaluate the jump condition
   always_comb begin
      unique case (ctl.cond)
         COND_NEVER:       take = 1'b0;
         COND_ALWAYS:      take = 1'b1;
         COND_NOT_FIRST:   take = !flags.first;
         COND_NOT_FULL:    take = !flags.full;
         COND_NOT_PARTIAL: take = !flags.partial;
         COND_NOT_LAST:    take = !flags.last;
         default:          take = 1'b0;
      endcase
   end

   // Advance the step counter
   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (!busy_ff) begin
         if (start) begin
            pc_in   = '0;
            busy_in = 1'b1;
         end
      end else if (!stall) begin
         if (ctl.fin) begin
            busy_in = 1'b0;
         end else if (take) begin
            pc_in = ctl.target;
         end else begin
            pc_in = pc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= '0;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
      end
   end

endmodule

`default_nettype wire

### rtl/murmur64_byte_hash_top.sv
// An accepted transaction occupies the microcode sequencer until its final step, and
// req_ready stays low meanwhile, so a new transaction is not taken before the last
// one is through. For a last item the result is registered on the final step. The
// single shared multiplier is used up to five times per transaction.
// Reset (synchronous, active high) clears seed, fold, running hash, byte count,
// expected length and partial flag, and empties the result register.
`default_nettype none

module murmur64_byte_hash_top #(
   parameter int LENGTH_WIDTH = m64h_pkg::LENGTH_WIDTH_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [63:0]                          req_data_word,
   input  wire logic [3:0]                           req_byte_count,
   input  wire logic                                 req_first_item,
   input  wire logic                                 req_last_item,
   input  wire logic [31:0]                          req_total_length,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [63:0]                               rsp_hash_value,
   output logic                                      rsp_length_mismatch,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [m64h_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [63:0]                          csr_data
);
   import m64h_pkg::*;

   localparam int LW = LENGTH_WIDTH;

   logic [63:0]   seed_ff, seed_in;
   logic          fold_ff, fold_in;
   logic [63:0]   word_ff, word_in;
   logic [3:0]    count_ff, count_in;
   logic          first_ff, first_in;
   logic          last_ff, last_in;
   logic          mis_ff, mis_in;
   logic [LW-1:0] bytes_ff, bytes_in;
   logic [LW-1:0] expected_ff, expected_in;
   logic          partial_ff, partial_in;
   logic [63:0]   h_ff, h_in;
   logic [63:0]   t_ff, t_in;
   logic [63:0]   out_hash_ff, out_hash_in;
   logic          out_mis_ff, out_mis_in;
   logic          out_valid_ff, out_valid_in;

   logic          req_take;
   logic          busy;
   logic          stall;
   logic          step;
   ctl_type       ctl;
   flags_type     flags;
   logic [63:0]   operand;
   logic [63:0]   product;
   logic [63:0]   part_mask;
   logic [63:0]   final_mix;
   logic [3:0]    count_c;
   logic [LW-1:0] base_bytes;
   logic          base_partial;
   logic [LW:0]   byte_sum;

   assign req_ready = !busy;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign rsp_valid           = out_valid_ff;
   assign rsp_hash_value      = out_hash_ff;
   assign rsp_length_mismatch = out_mis_ff;

   assign stall = (ctl.dest == DST_OUT) && out_valid_ff && !rsp_ready;
   assign step  = busy && !stall;

   assign flags.first   = first_ff;
   assign flags.full    = (count_ff == 4'(WORD_BYTES));
   assign flags.partial = (count_ff != 4'd0) && (count_ff != 4'(WORD_BYTES));
   assign flags.last    = last_ff;

   m64h_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (req_take),
      .stall (stall),
      .flags (flags),
      .busy  (busy),
      .ctl   (ctl)
   );

   // Select the multiplier operand
   always_comb begin
      unique case (ctl.src)
         SRC_LEN:      operand = 64'(expected_ff);
         SRC_WORD:     operand = word_ff;
         SRC_TMP:      operand = t_ff;
         SRC_HASH:     operand = h_ff;
         SRC_HASH_MIX: operand = shiftmix(h_ff);
         default:      operand = h_ff;
      endcase
   end

   m64h_mul u_mul (
      .clock   (clock),
      .issue   (step && ctl.issue),
      .operand (operand),
      .product (product)
   );

   // Keep only the bytes below the count
   always_comb begin
      for (int i = 0; i < WORD_BYTES; i++) begin
         part_mask[8*i +: 8] = (4'(i) < count_ff) ? 8'hff : 8'h00;
      end
   end

   assign final_mix = shiftmix(product);

   // Length bookkeeping for an incoming transaction
   always_comb begin
      count_c      = (req_byte_count > 4'(WORD_BYTES)) ? 4'(WORD_BYTES) : req_byte_count;
      base_bytes   = req_first_item ? '0 : bytes_ff;
      base_partial = req_first_item ? 1'b0 : partial_ff;
      byte_sum     = {1'b0, base_bytes} + (LW+1)'(count_c);
   end

   // Capture transactions and configuration
   always_comb begin
      seed_in     = seed_ff;
      fold_in     = fold_ff;
      word_in     = word_ff;
      count_in    = count_ff;
      first_in    = first_ff;
      last_in     = last_ff;
      mis_in      = mis_ff;
      bytes_in    = bytes_ff;
      expected_in = expected_ff;
      partial_in  = partial_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_SEED: seed_in = csr_data;
            REG_FOLD: fold_in = csr_data[0];
            default:  ;
         endcase
      end
      if (req_take) begin
         word_in     = req_data_word;
         count_in    = count_c;
         first_in    = req_first_item;
         last_in     = req_last_item;
         expected_in = req_first_item ? LW'(req_total_length) : expected_ff;
         bytes_in    = byte_sum[LW] ? '1 : byte_sum[LW-1:0];
         partial_in  = base_partial || ((count_c != 4'd0) && (count_c != 4'(WORD_BYTES)));
         mis_in      = (bytes_in != expected_in) || base_partial;
      end
   end

   // Write back the datapath per control word
   always_comb begin
      h_in         = h_ff;
      t_in         = t_ff;
      out_hash_in  = out_hash_ff;
      out_mis_in   = out_mis_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (step) begin
         unique case (ctl.dest)
            DST_NONE:    ;
            DST_H_SEED:  h_in = seed_ff ^ product;
            DST_TMP_MIX: t_in = final_mix;
            DST_H_XOR:   h_in = h_ff ^ product;
            DST_H_PART:  h_in = h_ff ^ (word_ff & part_mask);
            DST_H_LOAD:  h_in = product;
            DST_OUT: begin
               out_hash_in  = fold_ff ? {32'd0, final_mix[31:0] ^ final_mix[63:32]}
                                      : final_mix;
               out_mis_in   = mis_ff;
               out_valid_in = 1'b1;
            end
            default:     ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= '0;
         fold_ff      <= 1'b0;
         bytes_ff     <= '0;
         expected_ff  <= '0;
         partial_ff   <= 1'b0;
         h_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         seed_ff      <= seed_in;
         fold_ff      <= fold_in;
         bytes_ff     <= bytes_in;
         expected_ff  <= expected_in;
         partial_ff   <= partial_in;
         h_ff         <= h_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      count_ff    <= count_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      mis_ff      <= mis_in;
      t_ff        <= t_in;
      out_hash_ff <= out_hash_in;
      out_mis_ff  <= out_mis_in;
   end

endmodule

`default_nettype wire
